@@ rtl/core/sttbl_pkg.sv @@
// ----------------------------------------------------------------------------
// Software timer table package
// Shared types, field widths and operation codes for the one-shot timer table.
// ----------------------------------------------------------------------------
package sttbl_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam int FUNC_W  = 3;
  localparam int TID_W   = 8;
  localparam int QUEUE_W = 2;
  localparam int CODE_W  = 8;
  localparam int ARG_W   = 16;
  localparam int TOUT_W  = 16;

  localparam logic [FUNC_W-1:0] FUNC_TICK  = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_ADD   = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_DEL   = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_SETEN = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_QUERY = 3'd4;

  localparam logic KIND_EXPIRY = 1'b0;
  localparam logic KIND_DONE   = 1'b1;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [TID_W-1:0]   timer_id;
    logic [QUEUE_W-1:0] queue_sel;
    logic [CODE_W-1:0]  msg_code;
    logic [ARG_W-1:0]   msg_arg;
    logic [TOUT_W-1:0]  timeout;
    logic               enable_value;
  } in_item_t;

  typedef struct packed {
    logic               kind;
    logic [TID_W-1:0]   out_timer_id;
    logic [QUEUE_W-1:0] out_queue;
    logic [CODE_W-1:0]  out_msg_code;
    logic [ARG_W-1:0]   out_msg_arg;
    logic               exists;
    logic [TOUT_W-1:0]  remaining;
    logic               last;
  } out_item_t;

  // One table entry as stored in the RAM (51 bits).
  typedef struct packed {
    logic [TID_W-1:0]   timer_id;
    logic [QUEUE_W-1:0] queue;
    logic [CODE_W-1:0]  msg_code;
    logic [ARG_W-1:0]   msg_arg;
    logic [TOUT_W-1:0]  countdown;
    logic               en;
  } entry_t;

endpackage

@@ rtl/core/sttbl_ram.sv @@
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with a registered read data output.
// ----------------------------------------------------------------------------
module sttbl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/core/software_timer_table_top.sv @@
// ----------------------------------------------------------------------------
// Software timer table
// Compact table of one-shot timers kept in a RAM and walked by a sequencer.
// ----------------------------------------------------------------------------
// Steps: a tick, add or delete reads and examines each entry (SCAN, EXAM), adds
// REMOVE and MOVE per removal (REMOVE only when the last entry itself goes), makes
// a closing check in SCAN when the walk reaches the end and posts the done result;
// set enable and query use SLOT then DONE, only DONE when the slot is not in use.
// Throughput: one item at a time; the next transfer is taken after the done result.
// Reset clears the entry count and control state; the RAM is not cleared.
module software_timer_table_top (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  sttbl_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output sttbl_pkg::out_item_t out_data
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EXAM,
    ST_REMOVE,
    ST_MOVE,
    ST_SLOT,
    ST_DONE
  } state_t;

  state_t                            state_r, state_nxt;
  logic [sttbl_pkg::CNT_W-1:0]       count_r, count_nxt;
  logic [sttbl_pkg::CNT_W-1:0]       idx_r, idx_nxt;
  sttbl_pkg::in_item_t               item_r, item_nxt;
  logic [sttbl_pkg::TOUT_W-1:0]      rem_r, rem_nxt;
  logic                              out_valid_r, out_valid_nxt;
  sttbl_pkg::out_item_t              out_data_r, out_data_nxt;

  logic                              ram_we;
  logic [sttbl_pkg::IDX_W-1:0]       ram_waddr;
  sttbl_pkg::entry_t                 ram_wdata;
  logic                              ram_re;
  logic [sttbl_pkg::IDX_W-1:0]       ram_raddr;
  sttbl_pkg::entry_t                 cur;

  logic                              out_free;
  logic [sttbl_pkg::CNT_W-1:0]       last_slot;
  sttbl_pkg::entry_t                 new_entry;

  sttbl_ram #(
    .WIDTH ($bits(sttbl_pkg::entry_t)),
    .DEPTH (sttbl_pkg::TABLE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (cur)
  );

  assign out_free  = !out_valid_r || !out_stall;
  assign last_slot = count_r - sttbl_pkg::CNT_W'(1);
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign new_entry = '{
    timer_id:  item_r.timer_id,
    queue:     item_r.queue_sel,
    msg_code:  item_r.msg_code,
    msg_arg:   item_r.msg_arg,
    countdown: item_r.timeout,
    en:        1'b1
  };

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    item_nxt      = item_r;
    rem_nxt       = rem_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_waddr     = idx_r[sttbl_pkg::IDX_W-1:0];
    ram_wdata     = cur;
    ram_re        = 1'b0;
    ram_raddr     = idx_r[sttbl_pkg::IDX_W-1:0];

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          item_nxt = in_data;
          idx_nxt  = '0;
          rem_nxt  = '0;
          case (in_data.func) inside
            sttbl_pkg::FUNC_TICK, sttbl_pkg::FUNC_ADD, sttbl_pkg::FUNC_DEL: begin
              state_nxt = ST_SCAN;
            end
            sttbl_pkg::FUNC_SETEN, sttbl_pkg::FUNC_QUERY: begin
              // A slot beyond the live entries is ignored or reads as empty.
              if (in_data.timer_id < sttbl_pkg::TID_W'(count_r)) begin
                ram_re    = 1'b1;
                ram_raddr = in_data.timer_id[sttbl_pkg::IDX_W-1:0];
                state_nxt = ST_SLOT;
              end else begin
                state_nxt = ST_DONE;
              end
            end
            default: begin
              state_nxt = ST_DONE;
            end
          endcase
        end
      end

      ST_SCAN: begin
        if (idx_r < count_r) begin
          ram_re    = 1'b1;
          state_nxt = ST_EXAM;
        end else begin
          // An add that found no matching id appends if there is room.
          if (item_r.func == sttbl_pkg::FUNC_ADD &&
              count_r < sttbl_pkg::CNT_W'(sttbl_pkg::TABLE_DEPTH)) begin
            ram_we    = 1'b1;
            ram_waddr = count_r[sttbl_pkg::IDX_W-1:0];
            ram_wdata = new_entry;
            count_nxt = count_r + sttbl_pkg::CNT_W'(1);
          end
          state_nxt = ST_DONE;
        end
      end

      ST_EXAM: begin
        case (item_r.func)
          sttbl_pkg::FUNC_TICK: begin
            if (cur.countdown != '0) begin
              if (cur.en) begin
                ram_we              = 1'b1;
                ram_wdata.countdown = cur.countdown - sttbl_pkg::TOUT_W'(1);
              end
              idx_nxt   = idx_r + sttbl_pkg::CNT_W'(1);
              state_nxt = ST_SCAN;
            end else if (out_free) begin
              // The read data holds until the next read, so a stalled
              // output simply keeps the sequencer here.
              out_valid_nxt = 1'b1;
              out_data_nxt  = '{
                kind:         sttbl_pkg::KIND_EXPIRY,
                out_timer_id: cur.timer_id,
                out_queue:    cur.queue,
                out_msg_code: cur.msg_code,
                out_msg_arg:  cur.msg_arg,
                exists:       1'b0,
                remaining:    '0,
                last:         1'b0
              };
              state_nxt = ST_REMOVE;
            end
          end
          sttbl_pkg::FUNC_ADD: begin
            if (cur.timer_id == item_r.timer_id) begin
              ram_we    = 1'b1;
              ram_wdata = new_entry;
              state_nxt = ST_DONE;
            end else begin
              idx_nxt   = idx_r + sttbl_pkg::CNT_W'(1);
              state_nxt = ST_SCAN;
            end
          end
          default: begin
            if (cur.timer_id == item_r.timer_id) begin
              state_nxt = ST_REMOVE;
            end else begin
              idx_nxt   = idx_r + sttbl_pkg::CNT_W'(1);
              state_nxt = ST_SCAN;
            end
          end
        endcase
      end

      ST_REMOVE: begin
        // The last entry moves into the freed slot; it is skipped this pass.
        if (idx_r == last_slot) begin
          count_nxt = last_slot;
          idx_nxt   = idx_r + sttbl_pkg::CNT_W'(1);
          state_nxt = ST_SCAN;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = last_slot[sttbl_pkg::IDX_W-1:0];
          state_nxt = ST_MOVE;
        end
      end

      ST_MOVE: begin
        ram_we    = 1'b1;
        ram_wdata = cur;
        count_nxt = last_slot;
        idx_nxt   = idx_r + sttbl_pkg::CNT_W'(1);
        state_nxt = ST_SCAN;
      end

      ST_SLOT: begin
        if (item_r.func == sttbl_pkg::FUNC_SETEN) begin
          ram_we       = 1'b1;
          ram_waddr    = item_r.timer_id[sttbl_pkg::IDX_W-1:0];
          ram_wdata.en = item_r.enable_value;
        end else begin
          rem_nxt = cur.countdown;
        end
        state_nxt = ST_DONE;
      end

      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{
            kind:         sttbl_pkg::KIND_DONE,
            out_timer_id: '0,
            out_queue:    '0,
            out_msg_code: '0,
            out_msg_arg:  '0,
            exists:       (rem_r != '0),
            remaining:    rem_r,
            last:         1'b1
          };
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
    item_r     <= item_nxt;
    rem_r      <= rem_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

@@ rtl/core/sttbl_checker.sv @@
// ----------------------------------------------------------------------------
// Software timer table port checker
// Watches the top level's ports for handshake and sequencing slips.
// ----------------------------------------------------------------------------
module sttbl_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input sttbl_pkg::in_item_t  in_data,
  input logic                 out_valid,
  input logic                 out_stall,
  input sttbl_pkg::out_item_t out_data
);

  // A stalled input transfer keeps its valid and payload until it is taken.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("input changed while stalled");

  // A stalled result must be held until its transfer.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // The block works on one item at a time, so it is busy after a transfer.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again before the item finished");

  // Reset leaves the block idle with no result pending.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("block not idle after reset");

  // Only the done result closes an item, and expiry results carry no reply.
  a_kind_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.last == out_data.kind) &&
                  (out_data.kind == sttbl_pkg::KIND_DONE ||
                   (!out_data.exists && out_data.remaining == '0)))
    else $error("result kind and last flag disagree");

endmodule

bind software_timer_table_top sttbl_checker u_sttbl_checker (.*);
